FILE: rtl/bia_pkg.sv
// Shared types, constants and the find-first-zero function of the bitmap id allocator.
`timescale 1ns / 1ps
`default_nettype none
package bia_pkg;

	localparam int ID_W     = 15;
	localparam int ADDR_W   = 21;
	localparam int BASE_W   = 20;
	localparam int WORD_W   = 64;
	localparam int WORD_LSB = 6;

	localparam logic [BASE_W-1:0] BASE_RESET = 20'd2048;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_QUERY   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_MARK    = 2'd3
	} op_t;

	typedef logic [1:0] status_t;
	localparam status_t STS_OK       = 2'd0;
	localparam status_t STS_FULL     = 2'd1;
	localparam status_t STS_NOT_USED = 2'd2;

	typedef logic [BASE_W-1:0] base_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] entry_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [ADDR_W-1:0] entry_address;
		status_t           status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SUM_RD,
		S_SUM_CHK,
		S_LEAF_RD,
		S_LEAF_CHK,
		S_SUM_UPD_RD,
		S_SUM_UPD_WR,
		S_ADDR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                found;
		logic [WORD_LSB-1:0] idx;
	} ffz_t;

	// Lowest clear bit of a 64-bit word: each byte is searched on its own,
	// then the lowest byte that holds a clear bit is picked.
	function automatic ffz_t ffz64(input logic [WORD_W-1:0] w);
		ffz_t            r;
		logic [7:0]      hit;
		logic [7:0][2:0] low;
		for (int g = 0; g < 8; g++) begin
			hit[g] = ~&w[g*8 +: 8];
			low[g] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (!w[g*8+b]) begin
					low[g] = 3'(b);
				end
			end
		end
		r = '0;
		for (int g = 7; g >= 0; g--) begin
			if (hit[g]) begin
				r.found = 1'b1;
				r.idx   = {3'(g), low[g]};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bia_chan_if.sv
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface bia_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bia_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/bitmap_id_allocator_core.sv
// Top level of the bitmap id allocator: used/free map over ids 1..MAX_IDS.
//
// The block takes one request beat on req (op, entry_id) and returns exactly
// one result beat on rsp (result_id, entry_address, status). Allocate returns
// the lowest free id and marks it used; query, release and mark work on the
// given id. The entry address is table_base + (id-1)*ENTRY_BYTES, wrapped to
// 21 bits. The cfg channel writes table_base and is always ready.
//
// The map lives in a leaf RAM of 64-bit words, and a summary RAM keeps one
// "word full" bit per leaf word. Allocate scans summary words one at a time
// through a single shared find-first-zero unit, then searches the chosen leaf
// word with the same unit. A query reads the leaf word and forms the address;
// release, mark and a successful allocate also write the leaf word, then read
// and rewrite its summary word. The block holds one request at a time;
// req.ready is low while it works.
//
// After reset a clearing pass writes zero into every leaf and summary word,
// one word a cycle, over all SUM_WORDS*64 leaf addresses (256 by default);
// no request beat is taken meanwhile. The result sits in an output register,
// so a stalled receiver only delays the next result from being handed over.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_id_allocator_core
	import bia_pkg::*;
#(
	parameter int MAX_IDS     = 16384,
	parameter int ENTRY_BYTES = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	bia_chan_if.sink    req,
	bia_chan_if.source  rsp,
	bia_chan_if.sink    cfg
);

	localparam int MAP_WORDS  = (MAX_IDS + WORD_W - 1) / WORD_W;
	localparam int SUM_WORDS  = (MAP_WORDS + WORD_W - 1) / WORD_W;
	localparam int LEAF_DEPTH = SUM_WORDS * WORD_W;
	localparam int LW         = $clog2(LEAF_DEPTH);
	localparam int SW         = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
	localparam int BIT_W      = LW + WORD_LSB;
	localparam int EB_W       = $clog2(ENTRY_BYTES + 1);
	localparam int PW         = BIT_W + EB_W;

	state_t state_q, state_d;

	// Request and working registers.
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [BIT_W-1:0]  bidx_q;
	logic [SW-1:0]     sum_addr_q;
	logic              leaf_full_q;
	logic [LW-1:0]     clr_q;
	base_t             table_base_q;

	// Result and output registers.
	logic [ID_W-1:0]   res_id_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	// RAM ports.
	logic              leaf_we;
	logic [LW-1:0]     leaf_waddr;
	logic [WORD_W-1:0] leaf_wdata;
	logic [WORD_W-1:0] leaf_rdata;
	logic              sum_we;
	logic [SW-1:0]     sum_waddr;
	logic [WORD_W-1:0] sum_wdata;
	logic [SW-1:0]     sum_raddr;
	logic [WORD_W-1:0] sum_rdata;

	// Datapath.
	logic                req_beat;
	logic                req_id_ok;
	logic [LW-1:0]       leaf_word;
	logic [SW-1:0]       sum_upd_addr;
	logic [WORD_W-1:0]   ffz_in;
	ffz_t                ffz_r;
	logic [WORD_LSB-1:0] bit_pos;
	logic [WORD_W-1:0]   bit_mask;
	logic [WORD_W-1:0]   leaf_new;
	logic [WORD_W-1:0]   sum_new;
	logic [BIT_W-1:0]    cand_bidx;
	logic [BIT_W:0]      cand_id;
	logic                alloc_full;
	logic [LW-1:0]       found_word;
	logic [PW-1:0]       offset;
	logic [ADDR_W-1:0]   addr_calc;
	logic                out_free;

	assign req_beat  = req.valid && req.ready;
	assign req_id_ok = (req.data.entry_id != '0) &&
		(32'(req.data.entry_id) <= 32'(MAX_IDS));

	assign leaf_word    = bidx_q[BIT_W-1:WORD_LSB];
	assign sum_upd_addr = SW'(leaf_word >> WORD_LSB);

	// The one search unit serves the summary scan and the leaf search.
	assign ffz_in = (state_q == S_SUM_CHK) ? sum_rdata : leaf_rdata;
	assign ffz_r  = ffz64(ffz_in);

	assign bit_pos  = (op_q == OP_ALLOC) ? ffz_r.idx : bidx_q[WORD_LSB-1:0];
	assign bit_mask = WORD_W'(1) << bit_pos;
	assign leaf_new = (op_q == OP_RELEASE) ? (leaf_rdata & ~bit_mask) :
		(leaf_rdata | bit_mask);

	assign sum_new = leaf_full_q ?
		(sum_rdata | (WORD_W'(1) << leaf_word[WORD_LSB-1:0])) :
		(sum_rdata & ~(WORD_W'(1) << leaf_word[WORD_LSB-1:0]));

	// A free bit past MAX_IDS, in the last word or in padding, means full.
	assign cand_bidx  = {leaf_word, ffz_r.idx};
	assign cand_id    = (BIT_W + 1)'(cand_bidx) + (BIT_W + 1)'(1);
	assign alloc_full = !ffz_r.found || (cand_id > (BIT_W + 1)'(MAX_IDS));

	assign found_word = LW'({sum_addr_q, ffz_r.idx});

	assign offset    = PW'(bidx_q) * PW'(ENTRY_BYTES);
	assign addr_calc = ADDR_W'(table_base_q) + ADDR_W'(offset);

	assign out_free = !rsp_valid_q || rsp.ready;

	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		leaf_we    = 1'b0;
		leaf_waddr = leaf_word;
		leaf_wdata = leaf_new;
		sum_we     = 1'b0;
		sum_waddr  = sum_upd_addr;
		sum_wdata  = sum_new;
		sum_raddr  = sum_upd_addr;
		unique case (state_q)
			S_CLEAR: begin
				leaf_we    = 1'b1;
				leaf_waddr = clr_q;
				leaf_wdata = '0;
				sum_we     = (clr_q < LW'(SUM_WORDS));
				sum_waddr  = SW'(clr_q);
				sum_wdata  = '0;
				if (clr_q == LW'(LEAF_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.data.op == OP_ALLOC) begin
						state_d = S_SUM_RD;
					end else if (req_id_ok) begin
						state_d = S_LEAF_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SUM_RD: begin
				sum_raddr = sum_addr_q;
				state_d   = S_SUM_CHK;
			end
			S_SUM_CHK: begin
				if (ffz_r.found) begin
					state_d = S_LEAF_RD;
				end else if (sum_addr_q == SW'(SUM_WORDS - 1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SUM_RD;
				end
			end
			S_LEAF_RD: begin
				state_d = S_LEAF_CHK;
			end
			S_LEAF_CHK: begin
				if (op_q == OP_QUERY) begin
					state_d = S_ADDR;
				end else if (op_q == OP_ALLOC && alloc_full) begin
					state_d = S_DONE;
				end else begin
					leaf_we = 1'b1;
					state_d = S_SUM_UPD_RD;
				end
			end
			S_SUM_UPD_RD: begin
				state_d = S_SUM_UPD_WR;
			end
			S_SUM_UPD_WR: begin
				sum_we  = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			table_base_q <= BASE_RESET;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + LW'(1);
			end
			if (cfg.valid) begin
				table_base_q <= cfg.data;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_beat) begin
					op_q       <= req.data.op;
					id_q       <= req.data.entry_id;
					sum_addr_q <= '0;
					bidx_q     <= BIT_W'(req.data.entry_id - ID_W'(1));
					// An invalid id answers at once, with no map access.
					res_id_q   <= req.data.entry_id;
					res_addr_q <= '0;
					res_status_q <= (req.data.op == OP_QUERY) ? STS_NOT_USED : STS_OK;
				end
			end
			S_SUM_CHK: begin
				if (ffz_r.found) begin
					bidx_q <= {found_word, {WORD_LSB{1'b0}}};
				end else begin
					sum_addr_q <= sum_addr_q + SW'(1);
					res_id_q     <= '0;
					res_addr_q   <= '0;
					res_status_q <= STS_FULL;
				end
			end
			S_LEAF_CHK: begin
				leaf_full_q <= &leaf_new;
				unique case (op_q)
					OP_ALLOC: begin
						bidx_q[WORD_LSB-1:0] <= ffz_r.idx;
						res_id_q     <= alloc_full ? '0 : ID_W'(cand_id);
						res_addr_q   <= '0;
						res_status_q <= alloc_full ? STS_FULL : STS_OK;
					end
					OP_QUERY: begin
						res_id_q     <= id_q;
						res_status_q <= leaf_rdata[bit_pos] ? STS_OK : STS_NOT_USED;
					end
					OP_RELEASE, OP_MARK: begin
						res_id_q     <= id_q;
						res_status_q <= STS_OK;
					end
					default: begin
						res_id_q <= id_q;
					end
				endcase
			end
			S_ADDR: begin
				res_addr_q <= addr_calc;
			end
			S_DONE: begin
				if (out_free) begin
					rsp_data_q.result_id     <= res_id_q;
					rsp_data_q.entry_address <= res_addr_q;
					rsp_data_q.status        <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	bia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (LEAF_DEPTH)
	) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (leaf_word),
		.rdata (leaf_rdata)
	);

	bia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SUM_WORDS)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// A request beat is always followed by a busy cycle.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req.ready)
		else $error("request taken while the previous one is in work");

	// A full report never carries an id or an address.
	a_full_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status == STS_FULL) |->
		(rsp.data.result_id == '0 && rsp.data.entry_address == '0))
		else $error("full result carries an id or an address");

	// Outside the clearing pass the two RAMs are never written together.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> !(leaf_we && sum_we))
		else $error("leaf and summary written in the same cycle");

	// A leaf write is always followed by the summary update.
	a_leaf_then_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(leaf_we && state_q != S_CLEAR) |=> ##1 sum_we)
		else $error("summary not updated after a leaf write");

endmodule
`default_nettype wire
